/* rtl/lpm_pkg.sv */
package lpm_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned PORT_W = 8;

  // longest legal prefix, one past the msb position
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(32);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PORT_W-1:0] port_t;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } opcode_t;

  // one beat traveling down the cell chain; key is the prefix of a write
  // or the destination address of a lookup
  typedef struct packed {
    logic    valid;
    opcode_t opcode;
    idx_t    entry_index;
    addr_t   key;
    len_t    route_length;
    port_t   route_port;
    logic    found;
    len_t    best_len;
    port_t   best_port;
  } lpm_beat_t;

  function automatic len_t sat_length(input len_t len);
    return (len > FULL_LEN) ? FULL_LEN : len;
  endfunction

  // left-aligned mask, length already saturated
  function automatic addr_t length_to_mask(input len_t len);
    addr_t ones;
    ones = '1;
    return (len == '0) ? '0 : addr_t'(ones << (FULL_LEN - len));
  endfunction

endpackage

/* rtl/lpm_if.sv */
interface lpm_in_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  lpm_pkg::idx_t        entry_index;
  lpm_pkg::addr_t       route_prefix;
  lpm_pkg::len_t        route_length;
  lpm_pkg::port_t       route_port;
  lpm_pkg::addr_t       lookup_address;

  modport source (output valid, opcode, entry_index, route_prefix, route_length,
                  route_port, lookup_address, input ready);
  modport sink   (input valid, opcode, entry_index, route_prefix, route_length,
                  route_port, lookup_address, output ready);
endinterface

interface lpm_out_if;
  logic           valid;
  logic           ready;
  logic           hit;
  lpm_pkg::port_t out_port;
  lpm_pkg::len_t  match_length;

  modport source (output valid, hit, out_port, match_length, input ready);
  modport sink   (input valid, hit, out_port, match_length, output ready);
endinterface

/* rtl/lpm_cell.sv */
module lpm_cell #(
  parameter int unsigned CELL_ID = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  lpm_pkg::lpm_beat_t beat_in,
  output lpm_pkg::lpm_beat_t beat_out
);
  import lpm_pkg::*;

  logic      entry_valid_r;
  addr_t     prefix_r;
  addr_t     mask_r;
  len_t      len_r;
  port_t     port_r;
  lpm_beat_t beat_r;
  lpm_beat_t beat_nxt;

  logic  is_write;
  logic  is_lookup;
  logic  slot_hit;
  logic  match;
  logic  better;
  len_t  wr_len;

  assign is_write  = beat_in.valid && (beat_in.opcode == OP_WRITE);
  assign is_lookup = beat_in.valid && (beat_in.opcode == OP_LOOKUP);
  assign slot_hit  = (32'(beat_in.entry_index) == CELL_ID);
  assign wr_len    = sat_length(beat_in.route_length);

  // prefix is stored pre-masked
  assign match  = entry_valid_r && ((beat_in.key & mask_r) == prefix_r);
  // strict compare keeps the lower index on a tie
  assign better = is_lookup && match && (!beat_in.found || (len_r > beat_in.best_len));

  always_comb begin
    beat_nxt = beat_in;
    if (better) begin
      beat_nxt.found     = 1'b1;
      beat_nxt.best_len  = len_r;
      beat_nxt.best_port = port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
      beat_r.valid  <= 1'b0;
    end else if (advance) begin
      beat_r <= beat_nxt;
      if (is_write && slot_hit) begin
        entry_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_write && slot_hit) begin
      mask_r   <= length_to_mask(wr_len);
      prefix_r <= beat_in.key & length_to_mask(wr_len);
      len_r    <= wr_len;
      port_r   <= beat_in.route_port;
    end
  end

  assign beat_out = beat_r;

endmodule

/* rtl/longest_prefix_match_lookup.sv */
// ipv4 longest-prefix-match forwarding table
// in_ch carries write beats (opcode 1: slot, prefix, length, port) and lookup
// beats (opcode 0: destination address); out_ch returns one beat per lookup
// with hit, the winning port and its prefix length, all zero on a miss
// each table slot lives in its own cell; every beat walks the chain of cells
// one cell per cycle while the chain is not held, so a write lands in its slot
// in program order and a lookup only ever sees the writes that came before it
// throughput: one beat per cycle unless the receiver stalls, lookups and writes
// freely mixed; a result passes through every cell register of the chain and
// then the output register
// a slot index at or above TABLE_ENTRIES is dropped, lengths above 32 act as 32
// among matches of equal length the lower slot wins, a length-0 slot is the
// default route
// reset clears every slot's valid bit and empties the chain; the table is
// usable in the first cycle after reset
// when the receiver stalls with a result pending, the whole chain holds and
// in_ch.ready drops until that result is taken
module longest_prefix_match_lookup #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  lpm_in_if.sink    in_ch,
  lpm_out_if.source out_ch
);
  import lpm_pkg::*;

  // chain taps: beat[0] is the input, beat[k] leaves cell k-1
  lpm_beat_t beat [TABLE_ENTRIES+1];
  lpm_beat_t last_beat;

  logic  advance;
  logic  out_valid_r;
  logic  hit_r;
  port_t out_port_r;
  len_t  match_length_r;

  // chain moves when the result register is empty or being drained
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  always_comb begin
    beat[0].valid        = in_ch.valid;
    beat[0].opcode       = opcode_t'(in_ch.opcode);
    beat[0].entry_index  = in_ch.entry_index;
    beat[0].key          = (in_ch.opcode == OP_WRITE) ? in_ch.route_prefix
                                                      : in_ch.lookup_address;
    beat[0].route_length = in_ch.route_length;
    beat[0].route_port   = in_ch.route_port;
    beat[0].found        = 1'b0;
    beat[0].best_len     = '0;
    beat[0].best_port    = '0;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    lpm_cell #(
      .CELL_ID (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .beat_in  (beat[k]),
      .beat_out (beat[k+1])
    );
  end

  assign last_beat = beat[TABLE_ENTRIES];

  // output register; only lookups produce a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last_beat.valid && (last_beat.opcode == OP_LOOKUP);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_r          <= last_beat.found;
      out_port_r     <= last_beat.found ? last_beat.best_port : '0;
      match_length_r <= last_beat.found ? last_beat.best_len : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = hit_r;
  assign out_ch.out_port     = out_port_r;
  assign out_ch.match_length = match_length_r;

endmodule

/* verif/lpm_lookup_checker.sv */
module lpm_lookup_checker #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  lpm_in_if    in_ch,
  lpm_out_if   out_ch,
  output int   mismatch_count,
  output int   lookups_pending
);
  import lpm_pkg::*;

  typedef struct packed {
    logic  hit;
    port_t port;
    len_t  len;
  } route_result_t;

  // shadow forwarding table, length kept saturated
  addr_t slot_prefix [TABLE_ENTRIES];
  len_t  slot_len    [TABLE_ENTRIES];
  port_t slot_port   [TABLE_ENTRIES];
  logic  slot_valid  [TABLE_ENTRIES];

  route_result_t route_q[$];

  task automatic report_mismatch(input string what);
    $display("lpm mismatch @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic addr_t prefix_mask(input len_t len);
    if (len == '0) begin
      return '0;
    end
    return addr_t'({ADDR_W{1'b1}} << (ADDR_W - len));
  endfunction

  // longest match over the shadow table, lower slot kept on a tie
  function automatic route_result_t best_route(input addr_t dest);
    route_result_t r;
    addr_t         m;
    r = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      m = prefix_mask(slot_len[i]);
      if (slot_valid[i] && ((dest & m) == (slot_prefix[i] & m)) &&
          (!r.hit || slot_len[i] > r.len)) begin
        r.hit  = 1'b1;
        r.port = slot_port[i];
        r.len  = slot_len[i];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    route_result_t want;
    len_t          len;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_prefix[i] = '0;
        slot_len[i]    = '0;
        slot_port[i]   = '0;
        slot_valid[i]  = 1'b0;
      end
      route_q.delete();
    end else begin
      // results first: a result never belongs to a beat taken at this edge
      if (out_ch.valid && out_ch.ready) begin
        if (route_q.size() == 0) begin
          report_mismatch("result beat with no lookup outstanding");
        end else begin
          want = route_q.pop_front();
          if (out_ch.hit !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", out_ch.hit, want.hit));
          if (out_ch.out_port !== want.port)
            report_mismatch($sformatf("out_port %0d, expected %0d",
                                      out_ch.out_port, want.port));
          if (out_ch.match_length !== want.len)
            report_mismatch($sformatf("match_length %0d, expected %0d",
                                      out_ch.match_length, want.len));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (opcode_t'(in_ch.opcode) == OP_WRITE) begin
          if (in_ch.entry_index < TABLE_ENTRIES) begin
            len = (in_ch.route_length > FULL_LEN) ? FULL_LEN : in_ch.route_length;
            slot_prefix[in_ch.entry_index] = in_ch.route_prefix;
            slot_len[in_ch.entry_index]    = len;
            slot_port[in_ch.entry_index]   = in_ch.route_port;
            slot_valid[in_ch.entry_index]  = 1'b1;
          end
        end else begin
          route_q.push_back(best_route(in_ch.lookup_address));
        end
      end
    end
    lookups_pending <= route_q.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import lpm_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int          RANDOM_BEATS  = 1350;
  // chain of cells plus output register, with some slack
  localparam int          DRAIN_CYCLES  = TABLE_ENTRIES + 8;

  typedef struct {
    opcode_t opcode;
    idx_t    entry_index;
    addr_t   route_prefix;
    len_t    route_length;
    port_t   route_port;
    addr_t   lookup_address;
  } route_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // when set, neither side idles: back-to-back stretches
  logic steady = 1'b0;

  int mismatch_count;
  int lookups_pending;
  int stall_left;

  // prefixes handed to the block, used only to aim lookups and nested writes at the table
  addr_t known_prefix [TABLE_ENTRIES];
  logic  known_written[TABLE_ENTRIES];

  lpm_in_if  in_ch ();
  lpm_out_if out_ch ();

  longest_prefix_match_lookup #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lpm_lookup_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .lookups_pending (lookups_pending)
  );

  always #5 clk = ~clk;

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side back-pressure: mostly ready, short stalls, now and then a long one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 15) begin
      out_ch.ready <= 1'b0;
      stall_left   <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                  : $urandom_range(9, 39);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // idle cycles after a beat on the input side
  function automatic int gap_cycles();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ignored fields always carry junk so the block has to ignore them
  function automatic route_req_t make_write(input idx_t idx, input addr_t prefix,
                                            input len_t len, input port_t port);
    route_req_t r;
    r.opcode         = OP_WRITE;
    r.entry_index    = idx;
    r.route_prefix   = prefix;
    r.route_length   = len;
    r.route_port     = port;
    r.lookup_address = $urandom;
    return r;
  endfunction

  function automatic route_req_t make_lookup(input addr_t dest);
    route_req_t r;
    r.opcode         = OP_LOOKUP;
    r.entry_index    = idx_t'($urandom_range(0, 15));
    r.route_prefix   = $urandom;
    r.route_length   = len_t'($urandom_range(0, 63));
    r.route_port     = port_t'($urandom_range(0, 255));
    r.lookup_address = dest;
    return r;
  endfunction

  // keep the top keep_bits of base, randomize the rest
  function automatic addr_t blend_address(input addr_t base, input int keep_bits);
    addr_t keep;
    keep = (keep_bits == 0) ? '0 : addr_t'({ADDR_W{1'b1}} << (ADDR_W - keep_bits));
    return (base & keep) | (addr_t'($urandom) & ~keep);
  endfunction

  // called at a rising edge; valid stays high into the next beat unless a gap follows
  task automatic send_beat(input route_req_t r);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= r.opcode;
    in_ch.entry_index    <= r.entry_index;
    in_ch.route_prefix   <= r.route_prefix;
    in_ch.route_length   <= r.route_length;
    in_ch.route_port     <= r.route_port;
    in_ch.lookup_address <= r.lookup_address;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (r.opcode == OP_WRITE) begin
      known_prefix[r.entry_index]  = r.route_prefix;
      known_written[r.entry_index] = 1'b1;
    end
    gap = gap_cycles();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every lookup in flight has returned
  task automatic drain_lookups();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (lookups_pending != 0) @(posedge clk);
  endtask

  // random beat: mostly lookups aimed at table prefixes, writes nesting prefixes
  function automatic route_req_t random_beat();
    idx_t  slot;
    addr_t base;
    len_t  len;
    int    r;
    slot = idx_t'($urandom_range(0, TABLE_ENTRIES - 1));
    base = known_written[slot] ? known_prefix[slot] : addr_t'($urandom);
    if ($urandom_range(0, 99) < 25) begin
      r = $urandom_range(0, 99);
      if (r < 8) len = '0;                                     // default route
      else if (r < 16) len = len_t'($urandom_range(33, 63));   // saturates to 32
      else len = len_t'($urandom_range(1, 32));
      if ($urandom_range(0, 1) == 0) base = addr_t'($urandom);
      else base = blend_address(base, $urandom_range(0, 32));
      return make_write(idx_t'($urandom_range(0, 15)), base, len,
                        port_t'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 75) begin
      return make_lookup(blend_address(base, $urandom_range(0, 32)));
    end
    return make_lookup($urandom);
  endfunction

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_LOOKUP;
    in_ch.entry_index    = '0;
    in_ch.route_prefix   = '0;
    in_ch.route_length   = '0;
    in_ch.route_port     = '0;
    in_ch.lookup_address = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      known_prefix[i]  = '0;
      known_written[i] = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, ties, default route, full and saturated lengths
    send_beat(make_lookup(32'h0000_0000));                   // miss on empty table
    send_beat(make_lookup(32'hFFFF_FFFF));
    send_beat(make_write(4'd15, 32'h0A00_0000, 6'd8, 8'd7));
    send_beat(make_lookup(32'h0A12_3456));
    send_beat(make_lookup(32'h0B00_0000));                   // no match
    send_beat(make_write(4'd3, 32'h0A00_0000, 6'd8, 8'd200)); // same length, lower slot
    send_beat(make_lookup(32'h0AFF_FFFF));
    send_beat(make_write(4'd0, 32'h0000_0000, 6'd0, 8'd255)); // default route
    send_beat(make_lookup(32'hC0A8_0001));
    send_beat(make_write(4'd1, 32'h0A01_0203, 6'd32, 8'd0));
    send_beat(make_lookup(32'h0A01_0203));                   // host route
    send_beat(make_lookup(32'h0A01_0202));                   // falls back to /8
    send_beat(make_write(4'd2, 32'hFFFF_FFFF, 6'd63, 8'd1));  // length saturates
    send_beat(make_lookup(32'hFFFF_FFFF));
    send_beat(make_lookup(32'hFFFF_FFFE));
    send_beat(make_write(4'd4, 32'h8000_0000, 6'd1, 8'd2));
    send_beat(make_lookup(32'h8000_0001));
    send_beat(make_write(4'd5, 32'h0A0B_0000, 6'd33, 8'd3));
    send_beat(make_lookup(32'h0A0B_0000));
    send_beat(make_write(4'd0, 32'h1234_5678, 6'd16, 8'd9));  // default route overwritten
    send_beat(make_lookup(32'h4000_0000));
    send_beat(make_lookup(32'h1234_FFFF));
    send_beat(make_write(4'd15, 32'h0A00_0000, 6'd8, 8'd11)); // rewrite the tie loser
    send_beat(make_lookup(32'h0A00_0001));

    drain_lookups();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 150 == 0) begin
        steady <= ($urandom_range(0, 3) == 0);
      end
      if (n == 500 || n == 1000) begin
        drain_lookups();
      end
      send_beat(random_beat());
    end

    drain_lookups();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && lookups_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
